@@ rtl/hpwl_pkg.sv @@
package hpwl_pkg;

   // page number width, fixed by the word format
   localparam int PAGE_BITS   = 36;
   localparam int TABLE_PAGES = 32;
   localparam int COUNT_BITS  = 32;

   // protection write bit position
   localparam int WR_BIT = 1;

   // item modes
   localparam logic [1:0] MODE_TRACK     = 2'd0;
   localparam logic [1:0] MODE_UNTRACK   = 2'd1;
   localparam logic [1:0] MODE_FAULT     = 2'd2;
   localparam logic [1:0] MODE_REBALANCE = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_DONE       = 3'd0;
   localparam logic [2:0] KIND_FULL       = 3'd1;
   localparam logic [2:0] KIND_NOT_FOUND  = 3'd2;
   localparam logic [2:0] KIND_PROT       = 3'd3;
   localparam logic [2:0] KIND_NOT_LOCKED = 3'd4;

   // register indexes
   localparam logic CSR_TOP_N     = 1'b0;
   localparam logic CSR_LOCK_MASK = 1'b1;

   localparam int CSR_DATA_BITS = 6;

   typedef struct packed {
      logic [1:0]           mode;
      logic [PAGE_BITS-1:0] page_number;
      logic                 shared;
      logic [2:0]           prot;
   } req_type;

   typedef struct packed {
      logic [2:0]           kind;
      logic [PAGE_BITS-1:0] out_page;
      logic [2:0]           new_prot;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                  shared;
      logic [2:0]            prot_base;
      logic [2:0]            prot_now;
      logic [COUNT_BITS-1:0] count;
      logic [PAGE_BITS-1:0]  page;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_ACT,
      S_RK_I,
      S_RK_IWAIT,
      S_RK_JRD,
      S_RK_JCMP,
      S_RK_WR,
      S_EM_RD,
      S_EM_WAIT,
      S_EM_ERD,
      S_EM_DEC,
      S_FIN
   } state_type;

endpackage

@@ rtl/hot_page_write_lock_policy.sv @@
// Channel   Direction  Handshake             Word
// req       in         req_valid/req_stall   req_word  (mode, page, shared, prot)
// rsp       out        rsp_valid/rsp_stall   rsp_word  (kind, page, new_prot, last)
// csr       in         csr_wr_en             csr_index, csr_data
//
// Track, untrack and fault: a table scan that reads and then compares each entry in turn
// and stops at a hit, then an act state that waits for room in the output register.
// Rebalance: ranks each valid page against all others, then applies the new protections
// in rank order, all through the single read port of the entry memory.
// Synchronous reset empties the table (valid bits) and loads top_n 0, lock_mask 2.
// req_stall is high while an item is in progress; a stalled result holds the
// sequencer until the output register frees.
module hot_page_write_lock_policy #(
   parameter int TABLE_PAGES = hpwl_pkg::TABLE_PAGES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  hpwl_pkg::req_type                     req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output hpwl_pkg::rsp_type                     rsp_word,
   input  logic                                  csr_wr_en,
   input  logic                                  csr_index,
   input  logic [hpwl_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   import hpwl_pkg::*;

   localparam int IDX_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int CNT_W = $clog2(TABLE_PAGES + 1);
   localparam int ENT_W = $bits(entry_type);
   localparam int KEY_W = COUNT_BITS + PAGE_BITS;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_PAGES - 1);

   state_type state_ff, state_in;

   req_type                item_ff;
   logic [IDX_W-1:0]       idx_ff, jdx_ff, rnk_ff, r_ff, hit_ff, free_ff;
   logic [CNT_W-1:0]       nvalid_ff;
   logic                   found_ff, free_found_ff;
   entry_type              ent_ff;
   logic [KEY_W-1:0]       key_ff;
   logic                   pend_valid_ff;
   logic [PAGE_BITS-1:0]   pend_page_ff;
   logic [2:0]             pend_prot_ff;
   logic [5:0]             top_n_ff;
   logic [2:0]             lock_mask_ff;
   logic [TABLE_PAGES-1:0] valid_ff;
   logic                   out_valid_ff;
   rsp_type                out_ff;

   // memory ports
   logic             ent_wr_en;
   logic [IDX_W-1:0] ent_wr_addr, ent_rd_addr;
   entry_type        ent_wr_data, ent_rd;
   logic [ENT_W-1:0] ent_rd_raw;
   logic             rank_wr_en;
   logic [IDX_W-1:0] rank_wr_addr, rank_wr_data, rank_rd_addr, rank_rd;

   logic    push;
   rsp_type push_word;
   logic    can_push;

   hpwl_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_PAGES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_raw)
   );

   hpwl_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_PAGES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (rank_wr_addr),
      .wr_data (rank_wr_data),
      .rd_addr (rank_rd_addr),
      .rd_data (rank_rd)
   );

   assign ent_rd = entry_type'(ent_rd_raw);

   // entry decode
   logic scan_hit, j_beats, idx_last, j_last, r_last;
   logic act_writable, act_locked;
   logic dec_writable, dec_top, dec_unlock, dec_lock, dec_change;
   logic [COUNT_BITS-1:0] act_count_inc, dec_count_inc;
   logic [IDX_W-1:0] act_addr;

   assign scan_hit = valid_ff[idx_ff] && (ent_rd.page == item_ff.page_number);
   assign j_beats  = valid_ff[jdx_ff] && (jdx_ff != idx_ff) &&
                     ({ent_rd.count, ent_rd.page} > key_ff);
   assign idx_last = (idx_ff == IDX_LAST);
   assign j_last   = (jdx_ff == IDX_LAST);
   assign r_last   = ((CNT_W'(r_ff) + CNT_W'(1)) == nvalid_ff);

   assign act_writable  = !ent_ff.shared && ent_ff.prot_base[WR_BIT];
   assign act_locked    = act_writable && !ent_ff.prot_now[WR_BIT];
   assign act_count_inc = (ent_ff.count == '1) ? ent_ff.count : ent_ff.count + 1'b1;
   assign act_addr      = found_ff ? hit_ff : free_ff;

   assign dec_writable  = !ent_rd.shared && ent_rd.prot_base[WR_BIT];
   assign dec_top       = (7'(r_ff) < 7'(top_n_ff));
   assign dec_unlock    = dec_top && dec_writable && !ent_rd.prot_now[WR_BIT];
   assign dec_lock      = !dec_top && dec_writable && ent_rd.prot_now[WR_BIT];
   assign dec_change    = dec_unlock || dec_lock;
   assign dec_count_inc = (ent_rd.count == '1) ? ent_rd.count : ent_rd.count + 1'b1;

   assign can_push = !out_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_word.mode == MODE_REBALANCE) ? S_RK_I : S_SCAN_RD;
            end
         end
         S_SCAN_RD:  state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (scan_hit || idx_last) begin
               state_in = S_ACT;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_ACT: begin
            if (can_push) begin
               state_in = S_IDLE;
            end
         end
         S_RK_I: begin
            if (valid_ff[idx_ff]) begin
               state_in = S_RK_IWAIT;
            end else if (idx_last) begin
               state_in = (nvalid_ff != '0) ? S_EM_RD : S_FIN;
            end
         end
         S_RK_IWAIT: state_in = S_RK_JRD;
         S_RK_JRD:   state_in = S_RK_JCMP;
         S_RK_JCMP:  state_in = j_last ? S_RK_WR : S_RK_JRD;
         S_RK_WR:    state_in = idx_last ? S_EM_RD : S_RK_I;
         S_EM_RD:    state_in = S_EM_WAIT;
         S_EM_WAIT:  state_in = S_EM_ERD;
         S_EM_ERD:   state_in = S_EM_DEC;
         S_EM_DEC: begin
            if (!(dec_change && pend_valid_ff && !can_push)) begin
               state_in = r_last ? S_FIN : S_EM_RD;
            end
         end
         S_FIN: begin
            if (can_push) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory and result controls
   always_comb begin
      ent_rd_addr  = idx_ff;
      ent_wr_en    = 1'b0;
      ent_wr_addr  = act_addr;
      ent_wr_data  = ent_ff;
      rank_wr_en   = 1'b0;
      rank_wr_addr = rnk_ff;
      rank_wr_data = idx_ff;
      rank_rd_addr = r_ff;
      push         = 1'b0;
      push_word    = '{kind: KIND_DONE, out_page: item_ff.page_number,
                       new_prot: 3'd0, last: 1'b1};
      unique case (state_ff)
         S_RK_JRD: ent_rd_addr = jdx_ff;
         S_ACT: begin
            push = can_push;
            unique case (item_ff.mode)
               MODE_TRACK: begin
                  if (found_ff || free_found_ff) begin
                     ent_wr_en   = can_push;
                     ent_wr_data = '{shared: item_ff.shared, prot_base: item_ff.prot,
                                     prot_now: item_ff.prot, count: '0,
                                     page: item_ff.page_number};
                  end else begin
                     push_word.kind = KIND_FULL;
                  end
               end
               MODE_UNTRACK: begin
                  if (!found_ff) begin
                     push_word.kind = KIND_NOT_FOUND;
                  end
               end
               default: begin
                  if (!found_ff) begin
                     push_word.kind = KIND_NOT_FOUND;
                  end else if (!act_locked) begin
                     push_word.kind = KIND_NOT_LOCKED;
                  end else begin
                     ent_wr_en            = can_push;
                     ent_wr_data.prot_now = ent_ff.prot_base;
                     ent_wr_data.count    = act_count_inc;
                     push_word.kind       = KIND_PROT;
                     push_word.new_prot   = ent_ff.prot_base;
                  end
               end
            endcase
         end
         S_RK_WR: rank_wr_en = 1'b1;
         S_EM_DEC: begin
            ent_wr_addr = idx_ff;
            ent_wr_data = ent_rd;
            if (dec_unlock) begin
               ent_wr_data.prot_now = ent_rd.prot_base;
               ent_wr_data.count    = dec_count_inc;
            end else begin
               ent_wr_data.prot_now = ent_rd.prot_base & ~lock_mask_ff;
            end
            ent_wr_en = dec_change && (!pend_valid_ff || can_push);
            push      = dec_change && pend_valid_ff && can_push;
            push_word = '{kind: KIND_PROT, out_page: pend_page_ff,
                          new_prot: pend_prot_ff, last: 1'b0};
         end
         S_FIN: begin
            push = can_push;
            if (pend_valid_ff) begin
               push_word = '{kind: KIND_PROT, out_page: pend_page_ff,
                             new_prot: pend_prot_ff, last: 1'b1};
            end
         end
         default: ;
      endcase
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         top_n_ff      <= '0;
         lock_mask_ff  <= 3'd2;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TOP_N:     top_n_ff     <= csr_data;
               CSR_LOCK_MASK: lock_mask_ff <= csr_data[2:0];
               default: ;
            endcase
         end

         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end

         if (state_ff == S_ACT && can_push) begin
            if (item_ff.mode == MODE_TRACK && (found_ff || free_found_ff)) begin
               valid_ff[act_addr] <= 1'b1;
            end else if (item_ff.mode == MODE_UNTRACK && found_ff) begin
               valid_ff[hit_ff] <= 1'b0;
            end
         end

         if (state_ff == S_IDLE) begin
            pend_valid_ff <= 1'b0;
         end else if (state_ff == S_EM_DEC && dec_change && (!pend_valid_ff || can_push)) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (push) begin
         out_ff <= push_word;
      end
      unique case (state_ff)
         S_IDLE: begin
            item_ff       <= req_word;
            idx_ff        <= '0;
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
            nvalid_ff     <= '0;
            r_ff          <= '0;
         end
         S_SCAN_CMP: begin
            if (scan_hit) begin
               found_ff <= 1'b1;
               hit_ff   <= idx_ff;
               ent_ff   <= ent_rd;
            end else if (!valid_ff[idx_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_ff       <= idx_ff;
            end
            if (!idx_last) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_RK_I: begin
            if (!valid_ff[idx_ff] && !idx_last) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_RK_IWAIT: begin
            key_ff <= {ent_rd.count, ent_rd.page};
            jdx_ff <= '0;
            rnk_ff <= '0;
         end
         S_RK_JCMP: begin
            if (j_beats) begin
               rnk_ff <= rnk_ff + 1'b1;
            end
            if (!j_last) begin
               jdx_ff <= jdx_ff + 1'b1;
            end
         end
         S_RK_WR: begin
            nvalid_ff <= nvalid_ff + 1'b1;
            if (!idx_last) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_EM_WAIT: idx_ff <= rank_rd;
         S_EM_DEC: begin
            if (!(dec_change && pend_valid_ff && !can_push)) begin
               if (dec_change) begin
                  pend_page_ff <= ent_rd.page;
                  pend_prot_ff <= ent_wr_data.prot_now;
               end
               r_ff <= r_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   // checks
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (!out_valid_ff || !rsp_stall))
      else $error("result pushed over a held word");

   a_prot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.kind != KIND_PROT) |-> (rsp_word.new_prot == 3'd0))
      else $error("new_prot set on a non-protection result");

   a_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last) |-> (rsp_word.kind == KIND_PROT))
      else $error("non-final result that is not a protection change");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted item left the sequencer idle");

endmodule

@@ rtl/hpwl_ram.sv @@
module hpwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
